/* rtl/vlcp_pkg.sv */
// Shared types and constants for the variable-length code packer.
`default_nettype none

package vlcp_pkg;

  localparam int SYMBOL_COUNT    = 256;
  localparam int MAX_CODE_LEN    = 31;
  localparam int TAB_AW          = $clog2(SYMBOL_COUNT);
  localparam int FIRST_WORD_BITS = 31;
  localparam int WORD_BITS       = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PW        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_HEADER  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [4:0]  len;
    logic [30:0] code;
  } tab_entry_t;

  // Operation handed from the front end to the packer
  typedef struct packed {
    logic        is_flush;
    logic [4:0]  len;
    logic [30:0] code;
  } op_t;

endpackage

`default_nettype wire

/* rtl/vlcp_if.sv */
// Handshake interfaces for the input and result channels.
`default_nettype none

interface vlcp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  symbol;
  logic [4:0]  code_length;
  logic [30:0] code_bits;

  modport source (output valid, func, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, func, symbol, code_length, code_bits, output ready);
endinterface

interface vlcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] data;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, kind, data, byte_count, last, input ready);
  modport sink   (input valid, kind, data, byte_count, last, output ready);
endinterface

`default_nettype wire

/* rtl/vlcp_front.sv */
// Front end: accepts items, writes the code table, looks up codes.
`default_nettype none

module vlcp_front import vlcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vlcp_in_if.sink    in_i,
  output logic       q_valid_o,
  input  wire logic  q_ready_i,
  output op_t        q_item_o
);

  tab_entry_t tab_mem [SYMBOL_COUNT];
  tab_entry_t rdata_q;

  logic              accept;
  logic              in_range;
  logic [TAB_AW-1:0] addr;
  logic              tab_we;
  logic              tab_re;
  tab_entry_t        wdata;
  logic [4:0]        len_sat;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_flush_q, s1_flush_d;
  logic              s1_hit_q, s1_hit_d;

  assign in_i.ready = !s1_valid_q || q_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = 9'(in_i.symbol) < 9'(SYMBOL_COUNT);
  assign addr       = in_i.symbol[TAB_AW-1:0];

  always_comb begin
    len_sat    = (in_i.code_length > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN)
                                                       : in_i.code_length;
    wdata.len  = len_sat;
    // keep only the low len bits; a shift by 31 wraps to an all-ones mask
    wdata.code = in_i.code_bits & ((31'd1 << len_sat) - 31'd1);
    tab_we     = accept && (in_i.func == FUNC_LOAD) && in_range;
    tab_re     = accept && (in_i.func == FUNC_ENCODE);
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[addr] <= wdata;
    end
    if (tab_re) begin
      rdata_q <= tab_mem[addr];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q && !q_ready_i;
    s1_flush_d = s1_flush_q;
    s1_hit_d   = s1_hit_q;
    if (accept) begin
      case (in_i.func)
        FUNC_ENCODE: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b0;
          s1_hit_d   = in_range;
        end
        FUNC_FLUSH: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b1;
          s1_hit_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
      s1_hit_q   <= s1_hit_d;
    end
  end

  // a symbol beyond the table encodes as an empty code
  assign q_valid_o         = s1_valid_q;
  assign q_item_o.is_flush = s1_flush_q;
  assign q_item_o.len      = s1_hit_q ? rdata_q.len : 5'd0;
  assign q_item_o.code     = s1_hit_q ? rdata_q.code : 31'd0;

endmodule

`default_nettype wire

/* rtl/vlcp_queue.sv */
// Short FIFO between the front end and the packer.
`default_nettype none

module vlcp_queue import vlcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire op_t   push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output op_t        pop_item_o
);

  op_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                push, pop;

  assign push_ready_o = count_q != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/vlcp_back.sv */
// Packer: shifts codes into the word buffer and drives the result register.
`default_nettype none

module vlcp_back import vlcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  output logic       q_ready_o,
  input  wire op_t   q_item_i,
  vlcp_out_if.source out_o
);

  logic [31:0] buf_q, buf_d;
  logic [5:0]  free_q, free_d;
  logic        hdr_pend_q, hdr_pend_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [31:0] data_q, data_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        last_q, last_d;

  logic        go;
  logic        fits;
  logic        emit;
  logic [4:0]  rem_len;
  logic [31:0] full_word;
  logic [2:0]  flush_cnt;
  logic [31:0] flush_mask;

  assign go        = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_ready_o = go && (!q_item_i.is_flush || hdr_pend_q);

  always_comb begin
    fits      = {1'b0, q_item_i.len} <= free_q;
    emit      = q_item_i.is_flush || !fits;
    // only used when the code overflows, so free_q stays below 31
    rem_len   = q_item_i.len - free_q[4:0];
    full_word = (buf_q << free_q) | ({1'b0, q_item_i.code} >> rem_len);

    if (free_q < 6'd8) begin
      flush_cnt  = 3'd4;
      flush_mask = 32'hFFFF_FFFF;
    end else if (free_q < 6'd16) begin
      flush_cnt  = 3'd3;
      flush_mask = 32'h00FF_FFFF;
    end else if (free_q < 6'd24) begin
      flush_cnt  = 3'd2;
      flush_mask = 32'h0000_FFFF;
    end else begin
      flush_cnt  = 3'd1;
      flush_mask = 32'h0000_00FF;
    end
  end

  always_comb begin
    buf_d       = buf_q;
    free_d      = free_q;
    hdr_pend_d  = hdr_pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    if (go) begin
      if (q_item_i.is_flush) begin
        out_valid_d = 1'b1;
        if (!hdr_pend_q) begin
          kind_d     = KIND_PARTIAL;
          data_d     = buf_q & flush_mask;
          cnt_d      = flush_cnt;
          last_d     = 1'b0;
          hdr_pend_d = 1'b1;
        end else begin
          kind_d     = KIND_HEADER;
          data_d     = {26'd0, free_q};
          cnt_d      = 3'd1;
          last_d     = 1'b1;
          hdr_pend_d = 1'b0;
          buf_d      = '0;
          free_d     = 6'(FIRST_WORD_BITS);
        end
      end else if (fits) begin
        buf_d  = (buf_q << q_item_i.len) | {1'b0, q_item_i.code};
        free_d = free_q - {1'b0, q_item_i.len};
      end else begin
        // leading bits close the word; the whole code stays behind,
        // its already sent top bits drop out as the word refills
        out_valid_d = 1'b1;
        kind_d      = KIND_WORD;
        data_d      = full_word;
        cnt_d       = 3'd4;
        last_d      = 1'b0;
        buf_d       = {1'b0, q_item_i.code};
        free_d      = free_q + 6'(WORD_BITS) - {1'b0, q_item_i.len};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      free_q      <= 6'(FIRST_WORD_BITS);
      hdr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      free_q      <= free_d;
      hdr_pend_q  <= hdr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.data       = data_q;
  assign out_o.byte_count = cnt_q;
  assign out_o.last       = last_q;

endmodule

`default_nettype wire

/* rtl/variable_length_code_packer_top.sv */
// Variable-length code packer: prefix codes from a symbol table packed into 32-bit words.
//
// in_i carries one word per item: a table load (symbol, code_length, code_bits),
// an encode of one symbol, or a flush. out_o carries packed words, the final
// partial word of a message with its byte count, and then the free-bit header
// with last set. Both use valid/ready; a word moves when both are high.
// Loads complete on acceptance and give no result. An encode that fills the
// word passes the lookup register, the queue and the result register before it
// shows on out_o; a flush gives its partial word the same way, then the header.
// Throughput is one item per cycle while out_o is ready; a flush holds the packer
// until both of its results have entered the result register. The table read is
// registered, so the entry is there in the cycle after the symbol is taken; the word buffer updates by barrel shifts.
// A two-entry queue parts the table lookup from the packer, and the result
// register lets the packer keep going while out_o is stalled until that
// register is full; in_i then backs up through the queue.
// Reset clears the word buffer and sets 31 free bits; the code table is not
// cleared and an entry must be loaded before it is encoded.
`default_nettype none

module variable_length_code_packer_top import vlcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vlcp_in_if.sink    in_i,
  vlcp_out_if.source out_o
);

  logic fq_valid, fq_ready;
  op_t  fq_item;
  logic qb_valid, qb_ready;
  op_t  qb_item;

  vlcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_item_o  (fq_item)
  );

  vlcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  vlcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_ready_o (qb_ready),
    .q_item_i  (qb_item),
    .out_o     (out_o)
  );

  // header follows straight after the partial word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.kind == KIND_PARTIAL)
    |=> (out_o.valid && out_o.kind == KIND_HEADER))
    else $error("header did not follow partial word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready &&
     (in_i.func == FUNC_ENCODE || in_i.func == FUNC_FLUSH))
    |=> fq_valid)
    else $error("accepted encode or flush lost in front end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_valid && !fq_ready) |-> !in_i.ready)
    else $error("input taken while lookup stage is blocked");

endmodule

`default_nettype wire

/* dv/variable_length_code_packer_top_tb.sv */
// Self-checking testbench for the variable-length code packer: directed and random traffic, scoreboard.
`default_nettype none

module variable_length_code_packer_top_tb import vlcp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS = 30;

  typedef struct {
    kind_e       kind;
    logic [31:0] data;
    logic [2:0]  byte_count;
    logic        last;
  } out_word_t;

  logic clk;
  logic rst_n;

  vlcp_in_if  in_if();
  vlcp_out_if out_if();

  variable_length_code_packer_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Expected packer state
  tab_entry_t  code_table [SYMBOL_COUNT];
  logic [31:0] word_buf;
  int unsigned free_bits;
  out_word_t   pending_words[$];

  // Stimulus bookkeeping
  bit [SYMBOL_COUNT-1:0] entry_loaded;
  int  items_sent;
  int  mismatches;
  int  cycle_count;
  int  rx_hold;
  bit  rx_idle;
  bit  tx_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic push_word(input kind_e kind, input logic [31:0] data,
                           input logic [2:0] byte_count, input logic last);
    out_word_t w;
    w.kind = kind;
    w.data = data;
    w.byte_count = byte_count;
    w.last = last;
    pending_words = {pending_words, w};
  endtask

  task automatic predict_packer(input logic [1:0] func, input logic [7:0] sym,
                                input logic [4:0] len_in, input logic [30:0] code_in);
    logic [4:0]  len;
    logic [31:0] code;
    logic [2:0]  count;
    logic [31:0] data;
    case (func)
      FUNC_LOAD: begin
        code = (len_in == 0) ? 32'd0 : ({1'b0, code_in} & ((32'd1 << len_in) - 32'd1));
        code_table[sym].len = len_in;
        code_table[sym].code = code[30:0];
      end
      FUNC_ENCODE: begin
        len = code_table[sym].len;
        code = {1'b0, code_table[sym].code};
        if (len <= free_bits) begin
          word_buf = (word_buf << len) | code;
          free_bits -= len;
        end else begin
          // leading part closes the word, the rest opens the next
          word_buf = (word_buf << free_bits) | (code >> (len - free_bits));
          push_word(KIND_WORD, word_buf, 3'd4, 1'b0);
          word_buf = code;
          free_bits = free_bits + WORD_BITS - len;
        end
      end
      FUNC_FLUSH: begin
        count = 3'd1;
        if (free_bits < 24) count = 3'd2;
        if (free_bits < 16) count = 3'd3;
        if (free_bits < 8) count = 3'd4;
        data = (count == 3'd4) ? word_buf : (word_buf & ((32'd1 << (8 * count)) - 32'd1));
        push_word(KIND_PARTIAL, data, count, 1'b0);
        push_word(KIND_HEADER, 32'(free_bits & 32'hFF), 3'd1, 1'b1);
        word_buf = '0;
        free_bits = FIRST_WORD_BITS;
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    out_word_t w;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind=%0d data=%h", out_if.kind, out_if.data));
    end else begin
      w = pending_words.pop_front();
      if (out_if.kind !== w.kind)
        report_mismatch($sformatf("kind %0d, want %0d", out_if.kind, w.kind));
      if (out_if.data !== w.data)
        report_mismatch($sformatf("data %h, want %h", out_if.data, w.data));
      if (out_if.byte_count !== w.byte_count)
        report_mismatch($sformatf("byte_count %0d, want %0d", out_if.byte_count, w.byte_count));
      if (out_if.last !== w.last)
        report_mismatch($sformatf("last %b, want %b", out_if.last, w.last));
    end
  endtask

  // Both channels sampled on the same edge; results first, then the new item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        predict_packer(in_if.func, in_if.symbol, in_if.code_length, in_if.code_bits);
    end
  end

  // Result side: random stalls while rx_idle is set, plus a long hold when a test asks for one
  initial begin
    int gap;
    gap = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_if.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the word is taken
  task automatic send_item(input logic [1:0] func, input logic [7:0] sym,
                           input logic [4:0] len, input logic [30:0] code);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= func;
    in_if.symbol      <= sym;
    in_if.code_length <= len;
    in_if.code_bits   <= code;
    // ready only moves on the edge, so its mid-cycle value decides the next edge
    @(negedge clk);
    while (in_if.ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    if (func == FUNC_LOAD) entry_loaded[sym] = 1'b1;
    items_sent++;
  endtask

  task automatic load_symbol(input logic [7:0] sym, input logic [4:0] len,
                             input logic [30:0] code);
    send_item(FUNC_LOAD, sym, len, code);
  endtask

  task automatic encode_symbol(input logic [7:0] sym);
    send_item(FUNC_ENCODE, sym, 5'($urandom), 31'($urandom));
  endtask

  task automatic flush_message();
    send_item(FUNC_FLUSH, 8'($urandom), 5'($urandom), 31'($urandom));
  endtask

  function automatic logic [4:0] random_code_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'($urandom_range(24, 31));
    return 5'($urandom_range(1, 12));
  endfunction

  task automatic load_random(input logic [7:0] sym);
    load_symbol(sym, random_code_length(), 31'($urandom));
  endtask

  // Only loaded entries are ever read back
  task automatic encode_random();
    logic [7:0] sym;
    sym = 8'($urandom);
    if (!entry_loaded[sym]) load_random(sym);
    encode_symbol(sym);
  endtask

  task automatic pause_sender();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    flush_message();                               // empty message
    load_symbol(8'd0, 5'd0, 31'h7FFF_FFFF);        // zero length, stray code bits
    load_symbol(8'd255, 5'd31, 31'h7FFF_FFFF);
    load_symbol(8'd1, 5'd31, 31'h0000_0000);
    load_symbol(8'd2, 5'd3, 31'h7FFF_FFFA);        // code wider than its length
    load_symbol(8'd3, 5'd1, 31'h0000_0001);
    encode_symbol(8'd0);
    flush_message();
    encode_symbol(8'd255);                         // fills the short first word exactly
    encode_symbol(8'd3);                           // spills into the next word
    encode_symbol(8'd2);
    encode_symbol(8'd1);
    flush_message();
    send_item(FUNC_UNUSED, 8'hA5, 5'h1F, 31'h5555_5555);
    send_item(FUNC_UNUSED, 8'h5A, 5'h00, 31'h2AAA_AAAA);
    encode_symbol(8'd255);
    encode_symbol(8'd255);
    encode_symbol(8'd1);
    flush_message();
    encode_symbol(8'd2);
    encode_symbol(8'd3);
    flush_message();
  endtask

  task automatic test_random_messages(input int target);
    int r;
    int n;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(FUNC_UNUSED, 8'($urandom), 5'($urandom), 31'($urandom));
      end else if (r < 8) begin
        load_random(8'($urandom));
      end else if (r < 11) begin
        // broken message: flush with one or no symbols
        if (r == 10) encode_random();
        flush_message();
      end else begin
        n = $urandom_range(1, 40);
        repeat (n) encode_random();
        flush_message();
      end
    end
  endtask

  task automatic test_result_stall();
    load_symbol(8'd7, 5'd31, 31'($urandom));
    load_symbol(8'd8, 5'd30, 31'($urandom));
    rx_hold = 300;
    repeat (60) begin
      encode_symbol(8'd7);
      encode_symbol(8'd8);
    end
    flush_message();
  endtask

  initial begin
    entry_loaded = '0;
    items_sent = 0;
    mismatches = 0;
    rx_hold = 0;
    rx_idle = 1'b1;
    tx_idle = 1'b1;
    word_buf = '0;
    free_bits = FIRST_WORD_BITS;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_LOAD;
    in_if.symbol      <= '0;
    in_if.code_length <= '0;
    in_if.code_bits   <= '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_messages(1150);
    pause_sender();
    test_result_stall();
    pause_sender();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_messages(1500);

    pause_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_words.size() != 0) begin
      report_mismatch($sformatf("missing word kind=%0d data=%h",
                                pending_words[0].kind, pending_words[0].data));
      void'(pending_words.pop_front());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
